// File: src/assert_macros.svh
// Assertion macros shared by the axon delay queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SADQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define SADQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/sadq_pkg.sv
// Shared constants and register codes of the axon delay queue.
package sadq_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int DATA_W         = 16;
    localparam int TIMER_W        = 16;
    localparam int LEVEL_W        = 8;
    localparam int THR_W          = 15;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_POSTFIRE  = 3'd1,
        CFG_TRAVEL    = 3'd2,
        CFG_SPACING   = 3'd3,
        CFG_NO_RETURN = 3'd4,
        CFG_PULSE     = 3'd5,
        CFG_IDLE      = 3'd6
    } t_cfg_idx;

endpackage

// File: src/sadq_slot_mem.sv
// Timer slot memory with one occupied bit per slot.
module sadq_slot_mem
    import sadq_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [TIMER_W-1:0] o_rd_data,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [TIMER_W-1:0] i_wr_data,
    input  logic               i_clr_en,
    input  logic [AW-1:0]      i_clr_addr,
    output logic [SLOT_COUNT-1:0] o_occupied
);

    logic [TIMER_W-1:0]    r_mem [SLOT_COUNT];
    logic [TIMER_W-1:0]    r_rd_data;
    logic [SLOT_COUNT-1:0] r_occupied;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // A slot holds a live timer only while its occupied bit is set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occupied <= '0;
        end else begin
            if (i_wr_en) begin
                r_occupied[i_wr_addr] <= 1'b1;
            end
            if (i_clr_en) begin
                r_occupied[i_clr_addr] <= 1'b0;
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_occupied = r_occupied;

endmodule

// File: src/sadq_div.sv
// Restoring divider, one quotient bit per cycle.
module sadq_div
    import sadq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient,
    output logic [DATA_W-1:0] o_remainder
);

`include "assert_macros.svh"

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_div;
    logic [DATA_W:0]   w_trial;
    logic              w_fits;

    assign w_trial = {r_rem, r_quo[DATA_W-1]} - {1'b0, r_div};
    assign w_fits  = !w_trial[DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_trial[DATA_W-1:0] : {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
            r_quo <= {r_quo[DATA_W-2:0], w_fits};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    `SADQ_ASSERT(a_done_after_last_step, i_clk, i_rst_n,
        (r_busy && !i_start && r_step == STEP_W'(DATA_W - 1)) |=> (o_done && !r_busy),
        "divider did not finish after its last step")
    `SADQ_ASSERT(a_done_only_from_busy, i_clk, i_rst_n,
        o_done |-> $past(r_busy), "divider done without a running division")

endmodule

// File: src/spiking_axon_delay_queue.sv
// Top level of the axon delay queue: tick sequencer, configuration and output register.
//
// One input word is one update tick carrying the neuron potential (signed Q8.8).
// The input channel takes a word when i_in_valid is high and o_in_stall is low;
// o_in_stall stays high from acceptance until the result is placed in the output
// register. The result word (potential, drive level, queued count, fire flag)
// sits in that register under o_out_valid until a cycle with i_out_stall low,
// and the next tick may be accepted while it waits there.
// A tick walks the timer slots with one sequencer: a restoring divide of 16 quotient
// steps and a fill scan when the potential is above threshold, then a max search and a
// countdown pass (one memory read per cycle), a cancel step and an output step.
// Configuration words are taken at any time (o_cfg_ready is always high), and
// are meant to be written while no tick is in flight. Index 7 is ignored.
// Reset (synchronous, active low) empties all slots, clears the hold state and
// loads the register defaults. A stalled receiver holds the result word in place
// and stops the sequencer at its output cycle.
module spiking_axon_delay_queue
    import sadq_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_potential_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_potential_out,
    output logic [LEVEL_W-1:0]       o_drive_level,
    output logic [3:0]               o_queued_count,
    output logic                     o_fired_now,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);

`include "assert_macros.svh"

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIV    = 7'b0000010,
        S_FILL   = 7'b0000100,
        S_FIND   = 7'b0001000,
        S_CANCEL = 7'b0010000,
        S_TICK   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    // Configuration registers.
    logic [THR_W-1:0]        r_thr;
    logic signed [DATA_W-1:0] r_pfc;
    logic [TIMER_W-1:0]      r_travel;
    logic [TIMER_W-1:0]      r_spacing;
    logic [TIMER_W-1:0]      r_nrt;
    logic [LEVEL_W-1:0]      r_pulse;
    logic [LEVEL_W-1:0]      r_idle;

    // Sequencer state.
    t_state                  r_state, n_state;
    logic signed [DATA_W:0]  r_p, n_p;
    logic [DATA_W-1:0]       r_n, n_n;
    logic [DATA_W-1:0]       r_k, n_k;
    logic [TIMER_W-1:0]      r_d, n_d;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_lag_vld, n_lag_vld;
    logic [AW-1:0]           r_lag_idx, n_lag_idx;
    logic [TIMER_W-1:0]      r_best_val, n_best_val;
    logic [AW-1:0]           r_best_idx, n_best_idx;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_fired, n_fired;
    logic                    r_hold, n_hold;
    logic [LEVEL_W-1:0]      r_held, n_held;

    // Output register.
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_p, n_out_p;
    logic [LEVEL_W-1:0]       r_out_level, n_out_level;
    logic [3:0]               r_out_count, n_out_count;
    logic                     r_out_fired, n_out_fired;

    // Datapath and memory controls.
    logic                     w_accept;
    logic signed [DATA_W:0]   w_in_p;
    logic signed [DATA_W:0]   w_x;
    logic                     w_above;
    logic [DATA_W-1:0]        w_drop;
    logic [TIMER_W:0]         w_d_sum;
    logic [TIMER_W-1:0]       w_d_next;
    logic                     w_issue;
    logic                     w_last;
    logic [TIMER_W-1:0]       w_rd_val;
    logic [TIMER_W-1:0]       w_dec;
    logic                     w_rnz;
    logic signed [DATA_W:0]   w_neg_thr;
    logic                     w_div_done;
    logic [DATA_W-1:0]        w_quo;
    logic [DATA_W-1:0]        w_rem;
    logic [AW-1:0]            w_rd_addr;
    logic [TIMER_W-1:0]       w_rd_data;
    logic                     w_wr_en;
    logic [AW-1:0]            w_wr_addr;
    logic [TIMER_W-1:0]       w_wr_data;
    logic                     w_clr_en;
    logic [AW-1:0]            w_clr_addr;
    logic [SLOT_COUNT-1:0]    w_occ;
    logic                     w_out_free;

    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_in_p    = {i_potential_in[DATA_W-1], i_potential_in};
    assign w_x       = w_in_p - $signed({2'b00, r_thr});
    assign w_above   = !w_x[DATA_W] && (w_x != '0);
    // A non-negative post-fire change counts as a drop of one.
    assign w_drop    = r_pfc[DATA_W-1] ? DATA_W'(-r_pfc) : DATA_W'(1);
    assign w_d_sum   = {1'b0, r_d} + {1'b0, r_spacing};
    assign w_d_next  = w_d_sum[TIMER_W] ? {TIMER_W{1'b1}} : w_d_sum[TIMER_W-1:0];
    assign w_issue   = r_idx < CW'(SLOT_COUNT);
    assign w_last    = r_lag_vld && (r_lag_idx == AW'(SLOT_COUNT - 1));
    assign w_rd_addr = w_issue ? r_idx[AW-1:0] : '0;
    assign w_rd_val  = w_occ[r_lag_idx] ? w_rd_data : '0;
    assign w_dec     = w_rd_data - 1'b1;
    assign w_rnz     = (w_rem != '0);
    assign w_neg_thr = -$signed({2'b00, r_thr});
    assign w_out_free = !r_out_valid || !i_out_stall;

    sadq_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept && w_above),
        .i_dividend  (w_x[DATA_W-1:0]),
        .i_divisor   (w_drop),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    sadq_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (w_rd_addr),
        .o_rd_data  (w_rd_data),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .i_clr_en   (w_clr_en),
        .i_clr_addr (w_clr_addr),
        .o_occupied (w_occ)
    );

    always_comb begin
        n_state     = r_state;
        n_p         = r_p;
        n_n         = r_n;
        n_k         = r_k;
        n_d         = r_d;
        n_idx       = r_idx;
        n_lag_vld   = r_lag_vld;
        n_lag_idx   = r_lag_idx;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_cnt       = r_cnt;
        n_fired     = r_fired;
        n_hold      = r_hold;
        n_held      = r_held;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_p     = r_out_p;
        n_out_level = r_out_level;
        n_out_count = r_out_count;
        n_out_fired = r_out_fired;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx[AW-1:0];
        w_wr_data   = r_d;
        w_clr_en    = 1'b0;
        w_clr_addr  = r_lag_idx;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_p        = w_in_p;
                    n_idx      = '0;
                    n_lag_vld  = 1'b0;
                    n_best_val = '0;
                    n_best_idx = '0;
                    n_state    = w_above ? S_DIV : S_FIND;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    // p - n*drop equals thr + rem, less one drop when the division is inexact.
                    n_n     = w_quo + DATA_W'(w_rnz);
                    n_p     = $signed({2'b00, r_thr}) + $signed({1'b0, w_rem})
                              - (w_rnz ? $signed({1'b0, w_drop}) : $signed((DATA_W+1)'(0)));
                    n_k     = '0;
                    n_d     = r_travel;
                    n_idx   = '0;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if ((r_k == r_n) || !w_issue || ((r_d == '0) && (r_spacing == '0))) begin
                    n_idx      = '0;
                    n_lag_vld  = 1'b0;
                    n_best_val = '0;
                    n_best_idx = '0;
                    n_state    = S_FIND;
                end else if (r_d == '0) begin
                    // A zero delay pulse is dropped without taking a slot.
                    n_k = r_k + 1'b1;
                    n_d = w_d_next;
                end else if (!w_occ[r_idx[AW-1:0]]) begin
                    w_wr_en = 1'b1;
                    n_k     = r_k + 1'b1;
                    n_d     = w_d_next;
                    n_idx   = r_idx + 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FIND: begin
                n_lag_vld = w_issue;
                n_lag_idx = r_idx[AW-1:0];
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                // Strictly greater keeps the lowest index among equal times.
                if (r_lag_vld && (w_rd_val > r_best_val)) begin
                    n_best_val = w_rd_val;
                    n_best_idx = r_lag_idx;
                end
                if (w_last) begin
                    n_state = S_CANCEL;
                end
            end
            S_CANCEL: begin
                if ((r_p < w_neg_thr) && (r_best_val > r_nrt)) begin
                    w_clr_en   = 1'b1;
                    w_clr_addr = r_best_idx;
                    n_p        = r_p + $signed({2'b00, r_thr});
                end
                n_idx     = '0;
                n_lag_vld = 1'b0;
                n_cnt     = '0;
                n_fired   = 1'b0;
                n_state   = S_TICK;
            end
            S_TICK: begin
                n_lag_vld = w_issue;
                n_lag_idx = r_idx[AW-1:0];
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_lag_vld && w_occ[r_lag_idx]) begin
                    if (w_dec == '0) begin
                        w_clr_en = 1'b1;
                        n_fired  = 1'b1;
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_lag_idx;
                        w_wr_data = w_dec;
                        n_cnt     = r_cnt + 1'b1;
                    end
                end
                if (w_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    if (r_fired) begin
                        n_hold = 1'b1;
                        n_held = r_pulse;
                    end else if (r_hold) begin
                        n_hold = 1'b0;
                    end else begin
                        n_held = r_idle;
                    end
                    n_out_level = r_fired ? r_pulse : ((r_hold) ? r_held : r_idle);
                    if (r_p > (DATA_W+1)'(32767)) begin
                        n_out_p = {1'b0, {(DATA_W-1){1'b1}}};
                    end else if (r_p < -(DATA_W+1)'(32768)) begin
                        n_out_p = {1'b1, {(DATA_W-1){1'b0}}};
                    end else begin
                        n_out_p = r_p[DATA_W-1:0];
                    end
                    n_out_count = (32'(r_cnt) > 32'd15) ? 4'd15 : 4'(r_cnt);
                    n_out_fired = r_fired;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_lag_vld   <= 1'b0;
            r_hold      <= 1'b0;
            r_held      <= '0;
            r_fired     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_lag_vld   <= n_lag_vld;
            r_hold      <= n_hold;
            r_held      <= n_held;
            r_fired     <= n_fired;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p         <= n_p;
        r_n         <= n_n;
        r_k         <= n_k;
        r_d         <= n_d;
        r_lag_idx   <= n_lag_idx;
        r_best_val  <= n_best_val;
        r_best_idx  <= n_best_idx;
        r_cnt       <= n_cnt;
        r_out_p     <= n_out_p;
        r_out_level <= n_out_level;
        r_out_count <= n_out_count;
        r_out_fired <= n_out_fired;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THR_W'(256);
            r_pfc     <= -DATA_W'(256);
            r_travel  <= TIMER_W'(10);
            r_spacing <= TIMER_W'(5);
            r_nrt     <= TIMER_W'(5);
            r_pulse   <= LEVEL_W'(255);
            r_idle    <= LEVEL_W'(128);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_thr     <= i_cfg_data[THR_W-1:0];
                CFG_POSTFIRE:  r_pfc     <= i_cfg_data;
                CFG_TRAVEL:    r_travel  <= i_cfg_data;
                CFG_SPACING:   r_spacing <= i_cfg_data;
                CFG_NO_RETURN: r_nrt     <= i_cfg_data;
                CFG_PULSE:     r_pulse   <= i_cfg_data[LEVEL_W-1:0];
                CFG_IDLE:      r_idle    <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_potential_out = r_out_p;
    assign o_drive_level   = r_out_level;
    assign o_queued_count  = r_out_count;
    assign o_fired_now     = r_out_fired;
    assign o_cfg_ready     = 1'b1;

    `SADQ_ASSERT(a_result_from_out_state, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state == S_OUT),
        "result word appeared outside the output cycle")
    `SADQ_ASSERT(a_div_done_starts_fill, i_clk, i_rst_n,
        (r_state == S_DIV && w_div_done) |=> (r_state == S_FILL),
        "divide result not followed by the fill scan")
    `SADQ_ASSERT_NEVER(a_fill_count_bound, i_clk, i_rst_n,
        (r_state == S_FILL) && (r_k > r_n),
        "fill scan queued more pulses than the divide allowed")

endmodule
